### rtl/rrtt_pkg.sv
// Package for the round-robin task table: payload types, action and status
// codes, and the command and status structs between controller and datapath.
// No dependencies.
package rrtt_pkg;

    // Default number of task slots.
    localparam int NUM_SLOTS_DEF = 8;

    // Action codes of an input item.
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_KILL   = 2'd1;
    localparam logic [1:0] ACT_SWITCH = 2'd2;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_TASK  = 2'd2;
    localparam logic [1:0] ST_BAD_SLOT = 2'd3;

    // Input item.
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] task_handle;
        logic [2:0]  slot_index;
    } t_in;

    // Result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  result_slot;
        logic [15:0] run_handle;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the accepted input item
        logic init_scan;  // set the scan pointer and step count for the action
        logic step;       // advance the scan pointer by one slot
        logic add_write;  // store the handle in the slot under the pointer
        logic add_full;   // report a full table
        logic sw_hit;     // make the slot under the pointer current, read its handle
        logic sw_miss;    // clear the current slot, report no task
        logic sw_data;    // capture the handle read from the store
        logic kill;       // free the requested slot or flag it as bad
        logic nop;        // unused action
        logic emit;       // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] action;    // action of the latched item
        logic       slot_used; // valid bit of the slot under the pointer
        logic       last;      // this is the final slot of the scan
        logic       out_free;  // the output register can take a result
    } t_stat;

endpackage

### rtl/rrtt_ctrl.sv
// Controller state machine of the round-robin task table.
// Depends on rrtt_pkg for the command and status structs and action codes.
module rrtt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rrtt_pkg::t_stat i_stat,
    output rrtt_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_ADD     = 3'd2;
    localparam logic [2:0] S_SWITCH  = 3'd3;
    localparam logic [2:0] S_SW_READ = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.action)
                    rrtt_pkg::ACT_ADD: begin
                        o_cmd.init_scan = 1'b1;
                        n_state         = S_ADD;
                    end
                    rrtt_pkg::ACT_SWITCH: begin
                        o_cmd.init_scan = 1'b1;
                        n_state         = S_SWITCH;
                    end
                    rrtt_pkg::ACT_KILL: begin
                        o_cmd.kill = 1'b1;
                        n_state    = S_DONE;
                    end
                    default: begin
                        o_cmd.nop = 1'b1;
                        n_state   = S_DONE;
                    end
                endcase
            end
            S_ADD: begin
                if (!i_stat.slot_used) begin
                    o_cmd.add_write = 1'b1;
                    n_state         = S_DONE;
                end else if (i_stat.last) begin
                    o_cmd.add_full = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_SWITCH: begin
                if (i_stat.slot_used) begin
                    o_cmd.sw_hit = 1'b1;
                    n_state      = S_SW_READ;
                end else if (i_stat.last) begin
                    o_cmd.sw_miss = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_SW_READ: begin
                o_cmd.sw_data = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The handle read always follows a hit in the switch scan.
    a_read_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_READ) |-> ($past(r_state) == S_SWITCH))
        else $error("handle read state entered without a switch hit");

    // A scan ends by the last slot, never runs past it.
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ADD || r_state == S_SWITCH) && i_stat.last) |=>
        (r_state != S_ADD && r_state != S_SWITCH))
        else $error("slot scan continued past the last slot");

endmodule

### rtl/rrtt_datapath.sv
// Datapath of the round-robin task table: valid bits, handle store, current
// slot, scan pointer and result registers. Depends on rrtt_pkg.
module rrtt_datapath #(
    parameter int NUM_SLOTS = rrtt_pkg::NUM_SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rrtt_pkg::t_in   i_in,
    input  rrtt_pkg::t_cmd  i_cmd,
    output rrtt_pkg::t_stat o_stat,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output rrtt_pkg::t_out  o_out
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int XW = (IW > 3) ? IW : 3;
    localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_SLOTS - 1);

    rrtt_pkg::t_in  r_item;
    rrtt_pkg::t_out r_res;
    logic [NUM_SLOTS-1:0] r_valid;
    logic [15:0]    r_mem [NUM_SLOTS];
    logic [15:0]    r_rd;
    logic [IW-1:0]  r_ptr;
    logic [IW-1:0]  r_cnt;
    logic [IW-1:0]  r_cur;
    logic           r_none;

    logic [XW-1:0]  ptr_x;
    logic [XW-1:0]  idx_x;
    logic [IW-1:0]  kill_idx;
    logic           bad_slot;
    logic [IW-1:0]  ptr_next;
    logic [IW-1:0]  sw_start;

    assign ptr_x    = XW'(r_ptr);
    assign idx_x    = XW'(r_item.slot_index);
    assign kill_idx = idx_x[IW-1:0];
    assign bad_slot = (32'(r_item.slot_index) >= NUM_SLOTS);
    assign ptr_next = (r_ptr == LAST_SLOT) ? '0 : r_ptr + 1'b1;
    assign sw_start = r_none ? '0 : ((r_cur == LAST_SLOT) ? '0 : r_cur + 1'b1);

    // Status toward the controller.
    assign o_stat.action    = r_item.action;
    assign o_stat.slot_used = r_valid[r_ptr];
    assign o_stat.last      = (r_cnt == LAST_SLOT);
    assign o_stat.out_free  = !o_out_valid || i_out_ready;

    // Latched item, scan pointer and step count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
        if (i_cmd.init_scan) begin
            r_cnt <= '0;
            r_ptr <= (r_item.action == rrtt_pkg::ACT_SWITCH) ? sw_start : '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + 1'b1;
            r_ptr <= ptr_next;
        end
    end

    // Slot valid bits and current slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cur   <= '0;
            r_none  <= 1'b1;
        end else begin
            if (i_cmd.add_write) begin
                r_valid[r_ptr] <= 1'b1;
            end
            if (i_cmd.kill && !bad_slot) begin
                r_valid[kill_idx] <= 1'b0;
            end
            if (i_cmd.sw_hit) begin
                r_cur  <= r_ptr;
                r_none <= 1'b0;
            end else if (i_cmd.sw_miss) begin
                r_cur  <= '0;
                r_none <= 1'b1;
            end
        end
    end

    // Handle store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_write) begin
            r_mem[r_ptr] <= r_item.task_handle;
        end
        if (i_cmd.sw_hit) begin
            r_rd <= r_mem[r_ptr];
        end
    end

    // Result under construction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_write || i_cmd.sw_hit) begin
            r_res.status      <= rrtt_pkg::ST_OK;
            r_res.result_slot <= ptr_x[2:0];
            r_res.run_handle  <= '0;
        end else if (i_cmd.add_full) begin
            r_res <= '{status: rrtt_pkg::ST_FULL, result_slot: '0, run_handle: '0};
        end else if (i_cmd.sw_miss) begin
            r_res <= '{status: rrtt_pkg::ST_NO_TASK, result_slot: '0, run_handle: '0};
        end else if (i_cmd.kill) begin
            r_res.status      <= bad_slot ? rrtt_pkg::ST_BAD_SLOT : rrtt_pkg::ST_OK;
            r_res.result_slot <= '0;
            r_res.run_handle  <= '0;
        end else if (i_cmd.nop) begin
            r_res <= '{status: rrtt_pkg::ST_OK, result_slot: '0, run_handle: '0};
        end else if (i_cmd.sw_data) begin
            r_res.run_handle <= r_rd;
        end
    end

    // Output register; a result waits here until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out <= r_res;
        end
    end

    // A result is only loaded when the output register is free.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over an untransferred result");

    // An add stores into a slot that then reads as used.
    a_add_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_write |=> r_valid[$past(r_ptr)])
        else $error("add did not mark its slot used");

    // A full report only when every slot is used.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_full |-> (&r_valid))
        else $error("table reported full with a free slot");

    // A switch hit lands on a used slot.
    a_hit_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sw_hit |-> r_valid[r_ptr])
        else $error("switch chose a free slot");

endmodule

### rtl/round_robin_task_table_unit.sv
// Sequence per item: after decode, a kill or unused action builds its result directly.
// An add scans upward from slot 0 to the first free slot; a switch scans upward, wrapping,
// from the slot after the current one to the first used slot, then reads its handle.
// Throughput: one item at a time; the next item transfers in once the result sits in
// the output register. Reset (synchronous, active low) frees every slot, sets the
// current slot to none and empties the output register.
module round_robin_task_table_unit #(
    parameter int NUM_SLOTS = rrtt_pkg::NUM_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rrtt_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rrtt_pkg::t_out o_out
);

    rrtt_pkg::t_cmd  cmd;
    rrtt_pkg::t_stat stat;

    // Sequencer.
    rrtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Slot table and result path.
    rrtt_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for round_robin_task_table_unit: a queue-fed driver, a monitor,
// and a scheduler predictor that mirrors the slot table. Depends on rrtt_pkg and the RTL.
module testbench;

    localparam int  NUM_SLOTS   = rrtt_pkg::NUM_SLOTS_DEF;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  IDLE_PCT    = 12;
    localparam int  CALM_START  = 3000;
    localparam int  CALM_END    = 6000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // One pending transfer, optionally held back until all results are in.
    typedef struct {
        rrtt_pkg::t_in item;
        bit            drain;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    rrtt_pkg::t_in  in_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    rrtt_pkg::t_out o_out;

    t_pending       cmd_q[$];
    rrtt_pkg::t_out sched_expect_q[$];

    // Predictor state: the slot table as the block should hold it.
    bit          tb_slot_busy[NUM_SLOTS];
    logic [15:0] tb_slot_owner[NUM_SLOTS];
    int          tb_cur_slot = 0;
    bit          tb_cur_none = 1'b1;

    int cycle_count = 0;
    int fail_count = 0;
    int n_add = 0, n_kill = 0, n_switch = 0, n_unused = 0;
    int n_full = 0, n_no_task = 0, n_hits = 0;

    round_robin_task_table_unit #(.NUM_SLOTS(NUM_SLOTS)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out      (o_out)
    );

    always #2 i_clk = ~i_clk;

    // Work out the result of one action and update the predicted table.
    function automatic rrtt_pkg::t_out predict_schedule(rrtt_pkg::t_in item);
        rrtt_pkg::t_out res;
        int   pos;
        bit   found;
        res = '0;
        res.status = rrtt_pkg::ST_OK;
        found = 1'b0;
        case (item.action)
            rrtt_pkg::ACT_ADD: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!found && !tb_slot_busy[i]) begin
                        tb_slot_busy[i] = 1'b1;
                        tb_slot_owner[i] = item.task_handle;
                        res.result_slot = i[2:0];
                        found = 1'b1;
                    end
                end
                if (!found) res.status = rrtt_pkg::ST_FULL;
            end
            rrtt_pkg::ACT_KILL: begin
                if (int'(item.slot_index) >= NUM_SLOTS) begin
                    res.status = rrtt_pkg::ST_BAD_SLOT;
                end else begin
                    tb_slot_busy[item.slot_index] = 1'b0;
                    tb_slot_owner[item.slot_index] = '0;
                end
            end
            rrtt_pkg::ACT_SWITCH: begin
                pos = tb_cur_none ? 0 : tb_cur_slot + 1;
                for (int n = 0; n < NUM_SLOTS; n++) begin
                    if (pos >= NUM_SLOTS) pos = 0;
                    if (!found && tb_slot_busy[pos]) begin
                        tb_cur_slot = pos;
                        tb_cur_none = 1'b0;
                        res.result_slot = pos[2:0];
                        res.run_handle = tb_slot_owner[pos];
                        found = 1'b1;
                    end
                    if (!found) pos++;
                end
                if (!found) begin
                    tb_cur_slot = 0;
                    tb_cur_none = 1'b1;
                    res.status = rrtt_pkg::ST_NO_TASK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic push_cmd(logic [1:0] act, logic [15:0] handle, logic [2:0] index,
                            bit drain);
        t_pending p;
        p.item.action = act;
        p.item.task_handle = handle;
        p.item.slot_index = index;
        p.drain = drain;
        cmd_q.push_back(p);
    endtask

    // Driver: present queued items, predict each one at its transfer.
    always @(posedge i_clk) begin
        logic fire;
        logic idle;
        rrtt_pkg::t_out want;
        fire = in_valid && o_in_ready;
        idle = !(cycle_count >= CALM_START && cycle_count < CALM_END) &&
               ($urandom_range(0, 99) < IDLE_PCT);
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (fire) begin
                want = predict_schedule(in_data);
                sched_expect_q.push_back(want);
                case (in_data.action)
                    rrtt_pkg::ACT_ADD:    n_add++;
                    rrtt_pkg::ACT_KILL:   n_kill++;
                    rrtt_pkg::ACT_SWITCH: n_switch++;
                    default:              n_unused++;
                endcase
                if (want.status == rrtt_pkg::ST_FULL) n_full++;
                if (want.status == rrtt_pkg::ST_NO_TASK) n_no_task++;
                if (in_data.action == rrtt_pkg::ACT_SWITCH && want.status == rrtt_pkg::ST_OK)
                    n_hits++;
            end
            if (!in_valid || fire) begin
                if (cmd_q.size() != 0 && !idle &&
                    (!cmd_q[0].drain || (sched_expect_q.size() == 0 && !fire))) begin
                    in_valid <= 1'b1;
                    in_data <= cmd_q[0].item;
                    void'(cmd_q.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        rrtt_pkg::t_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (sched_expect_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: unexpected result status=%0d slot=%0d handle=%h",
                             o_out.status, o_out.result_slot, o_out.run_handle);
            end else begin
                want = sched_expect_q.pop_front();
                if (o_out.status !== want.status || o_out.result_slot !== want.result_slot ||
                    o_out.run_handle !== want.run_handle) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"ERROR: result mismatch: expected status=%0d slot=%0d ",
                                  "handle=%h, got status=%0d slot=%0d handle=%h"},
                                 want.status, want.result_slot, want.run_handle,
                                 o_out.status, o_out.result_slot, o_out.run_handle);
                end
            end
        end
        out_ready <= (cycle_count >= CALM_START && cycle_count < CALM_END) ||
                     ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        int add_w;
        int r;
        logic [1:0] act;
        // Directed: empty switch, fill, full, wrap, kills of current and free slots.
        push_cmd(rrtt_pkg::ACT_SWITCH, 16'h0000, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_ADD, 16'h0000, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_ADD, 16'hFFFF, 3'd7, 1'b0);
        push_cmd(rrtt_pkg::ACT_ADD, 16'hAAAA, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_ADD, 16'h5555, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_ADD, 16'h1234, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_ADD, 16'h8001, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_ADD, 16'h7FFE, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_ADD, 16'hC3C3, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_ADD, 16'hBEEF, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_SWITCH, 16'h0000, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_KILL, 16'h0000, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_SWITCH, 16'h0000, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_KILL, 16'hFFFF, 3'd0, 1'b0);
        push_cmd(ACT_UNUSED, 16'hFFFF, 3'd7, 1'b0);
        push_cmd(rrtt_pkg::ACT_KILL, 16'h0000, 3'd7, 1'b0);
        for (int s = 2; s <= 5; s++) push_cmd(rrtt_pkg::ACT_KILL, 16'h0000, s[2:0], 1'b0);
        push_cmd(rrtt_pkg::ACT_SWITCH, 16'h0000, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_KILL, 16'h0000, 3'd1, 1'b0);
        // Only one task left, so the search comes back to the current slot.
        push_cmd(rrtt_pkg::ACT_SWITCH, 16'h0000, 3'd0, 1'b0);
        push_cmd(rrtt_pkg::ACT_KILL, 16'h0000, 3'd6, 1'b0);
        push_cmd(rrtt_pkg::ACT_SWITCH, 16'h0000, 3'd0, 1'b0);

        // Random phases with a varying add bias so the table swings between full and empty.
        for (int p = 0; p < 19; p++) begin
            add_w = $urandom_range(15, 70);
            for (int k = 0; k < 100; k++) begin
                r = $urandom_range(0, 99);
                if (r < 4) act = ACT_UNUSED;
                else if (r < 4 + add_w) act = rrtt_pkg::ACT_ADD;
                else if (r < 4 + add_w + (96 - add_w) / 2) act = rrtt_pkg::ACT_KILL;
                else act = rrtt_pkg::ACT_SWITCH;
                push_cmd(act, 16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)),
                         ((p * 100 + k) % 150) == 0);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_q.size() != 0 || in_valid) @(posedge i_clk);
        while (sched_expect_q.size() != 0) @(posedge i_clk);
        repeat (NUM_SLOTS + 12) @(posedge i_clk);

        $display("Covered %0d adds (%0d full), %0d kills, %0d switches, %0d unused actions.",
                 n_add, n_full, n_kill, n_switch, n_unused);
        $display("Switches found a task %0d times and an empty table %0d times.",
                 n_hits, n_no_task);
        if (fail_count == 0 && sched_expect_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### round_robin_task_table_unit.f
rtl/rrtt_pkg.sv
rtl/rrtt_ctrl.sv
rtl/rrtt_datapath.sv
rtl/round_robin_task_table_unit.sv
tb/testbench.sv
